>>> rtl/core/lrpe_pkg.sv
// Package: shared types, codes and defaults for the LR parse engine.
`timescale 1ns / 1ps
`default_nettype none
package lrpe_pkg;

    localparam int STATES_DEF      = 256;
    localparam int SYMBOLS_DEF     = 64;
    localparam int RULES_DEF       = 64;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int MAX_RHS_DEF     = 15;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 16;
    localparam int SYM_W      = 6;
    localparam int VAL_W      = 8;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_LD_ACT = 3'd1,
        CMD_LD_RUL = 3'd2,
        CMD_LD_MAP = 3'd3,
        CMD_CHAR   = 3'd4,
        CMD_END    = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_ACCEPT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        V_PARSING = 2'd0,
        V_ACCEPT  = 2'd1,
        V_REJECT  = 2'd2
    } verdict_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMAP,
        ST_TOP,
        ST_LOOK,
        ST_ACT,
        ST_RULE,
        ST_GSTK,
        ST_GLOOK,
        ST_GACT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_en;
        logic map_chk;
        logic stk_base;
        logic act_goto;
        logic act_eval;
        logic rule_eval;
        logic goto_eval;
        logic out_load;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       parsing;
        logic       clr_last;
        logic       map_ok;
        logic       act_more;
        logic       rule_ok;
        logic       goto_ok;
        logic       out_free;
    } sts_t;

endpackage
`default_nettype wire

>>> rtl/core/lrpe_ctrl.sv
// Controller: sequences table reads, reductions and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module lrpe_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lrpe_pkg::sts_t sts,
    output lrpe_pkg::ctl_t     ctl
);

    lrpe_pkg::state_t state_reg;
    lrpe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lrpe_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lrpe_pkg::ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = lrpe_pkg::ST_IDLE;
                end
            end
            lrpe_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (lrpe_pkg::cmd_t'(sts.cmd))
                        lrpe_pkg::CMD_CHAR:
                            state_next = sts.parsing ? lrpe_pkg::ST_CMAP : lrpe_pkg::ST_DONE;
                        lrpe_pkg::CMD_END:
                            state_next = sts.parsing ? lrpe_pkg::ST_TOP : lrpe_pkg::ST_DONE;
                        default:
                            state_next = lrpe_pkg::ST_DONE;
                    endcase
                end
            end
            lrpe_pkg::ST_CMAP:
                state_next = sts.map_ok ? lrpe_pkg::ST_TOP : lrpe_pkg::ST_DONE;
            lrpe_pkg::ST_TOP:
                state_next = lrpe_pkg::ST_LOOK;
            lrpe_pkg::ST_LOOK:
                state_next = lrpe_pkg::ST_ACT;
            lrpe_pkg::ST_ACT:
                state_next = sts.act_more ? lrpe_pkg::ST_RULE : lrpe_pkg::ST_DONE;
            lrpe_pkg::ST_RULE:
                state_next = sts.rule_ok ? lrpe_pkg::ST_GSTK : lrpe_pkg::ST_DONE;
            lrpe_pkg::ST_GSTK:
                state_next = lrpe_pkg::ST_GLOOK;
            lrpe_pkg::ST_GLOOK:
                state_next = lrpe_pkg::ST_GACT;
            lrpe_pkg::ST_GACT:
                state_next = sts.goto_ok ? lrpe_pkg::ST_TOP : lrpe_pkg::ST_DONE;
            lrpe_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = lrpe_pkg::ST_IDLE;
                end
            end
            default:
                state_next = lrpe_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == lrpe_pkg::ST_IDLE);
        ctl           = '0;
        ctl.capture   = (state_reg == lrpe_pkg::ST_IDLE) && in_valid;
        ctl.clr_en    = (state_reg == lrpe_pkg::ST_CLEAR);
        ctl.map_chk   = (state_reg == lrpe_pkg::ST_CMAP);
        ctl.stk_base  = (state_reg == lrpe_pkg::ST_GSTK);
        ctl.act_goto  = (state_reg == lrpe_pkg::ST_GLOOK);
        ctl.act_eval  = (state_reg == lrpe_pkg::ST_ACT);
        ctl.rule_eval = (state_reg == lrpe_pkg::ST_RULE);
        ctl.goto_eval = (state_reg == lrpe_pkg::ST_GACT);
        ctl.out_load  = (state_reg == lrpe_pkg::ST_DONE) && sts.out_free;
    end

endmodule
`default_nettype wire

>>> rtl/core/lrpe_dp.sv
// Datapath: tables, parse stack, stack pointer, verdict and output word.
`timescale 1ns / 1ps
`default_nettype none
module lrpe_dp #(
    parameter int STATES      = lrpe_pkg::STATES_DEF,
    parameter int SYMBOLS     = lrpe_pkg::SYMBOLS_DEF,
    parameter int RULES       = lrpe_pkg::RULES_DEF,
    parameter int STACK_DEPTH = lrpe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_RHS     = lrpe_pkg::MAX_RHS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [lrpe_pkg::IN_DATA_W-1:0]  in_data,
    input  wire logic [lrpe_pkg::IN_USER_W-1:0]  in_user,
    input  wire logic                            cfg_wen,
    input  wire logic [lrpe_pkg::SYM_W-1:0]      cfg_wdata,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [lrpe_pkg::OUT_DATA_W-1:0]      out_data,
    input  wire lrpe_pkg::ctl_t                  ctl,
    output lrpe_pkg::sts_t                       sts
);

    localparam int ADEPTH = STATES * SYMBOLS;
    localparam int AAW    = $clog2(ADEPTH);
    localparam int SAW    = $clog2(STACK_DEPTH);
    localparam int SPW    = $clog2(STACK_DEPTH + 1);
    localparam int RAW    = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int RLIMIT = STATES + 2 * STACK_DEPTH;
    localparam int CW     = $clog2(RLIMIT + 1);

    logic [7:0] in_state;
    logic [5:0] in_sym;
    logic [7:0] in_char;
    logic [1:0] in_kind;
    logic [7:0] in_val;
    logic [5:0] in_rnum;
    logic [3:0] in_rlen;
    logic [5:0] in_rleft;
    lrpe_pkg::cmd_t in_cmd;

    assign in_state = in_data[7:0];
    assign in_sym   = in_data[13:8];
    assign in_char  = in_data[21:14];
    assign in_kind  = in_data[23:22];
    assign in_val   = in_data[31:24];
    assign in_rnum  = in_data[37:32];
    assign in_rlen  = in_data[41:38];
    assign in_rleft = in_data[47:42];
    assign in_cmd   = lrpe_pkg::cmd_t'(in_user);

    logic [9:0] act_mem [ADEPTH];
    logic [9:0] rule_mem [RULES];
    logic [5:0] cmap_mem [256];
    logic [7:0] stk_mem [STACK_DEPTH];

    logic [255:0]     cmap_vld_reg;
    logic [SPW-1:0]   sp_reg;
    logic [SPW-1:0]   base_reg;
    logic [1:0]       verdict_reg;
    logic [5:0]       end_sym_reg;
    logic [5:0]       sym_reg;
    logic [5:0]       left_reg;
    logic             at_end_reg;
    logic [CW-1:0]    count_reg;
    logic [AAW-1:0]   clr_cnt_reg;
    logic             out_valid_reg;
    logic [10:0]      out_data_reg;

    logic [9:0] act_rd_reg;
    logic       act_oob_reg;
    logic [9:0] rule_rd_reg;
    logic [5:0] cmap_rd_reg;
    logic       cmap_ok_reg;
    logic [7:0] stk_rd_reg;

    logic [31:0]    a_st;
    logic [31:0]    a_sym;
    logic [31:0]    a_lin;
    logic           a_oob;
    logic [AAW-1:0] act_raddr;
    logic           act_we;
    logic [AAW-1:0] act_waddr;
    logic [9:0]     act_wdata;
    logic [31:0]    ld_lin;
    logic           ld_act_ok;

    logic [1:0]     act_kind;
    logic [7:0]     act_val;
    logic [31:0]    rv;
    logic [31:0]    rn_ext;
    logic [3:0]     r_len;
    logic [SPW-1:0] sp_m1;
    logic [SPW-1:0] base_m1;
    logic [SAW-1:0] stk_raddr;
    logic           stk_we;
    logic [SAW-1:0] stk_waddr;
    logic [7:0]     stk_wdata;
    logic           shift_ok;
    logic           red_ok;
    logic           rule_ok;
    logic           goto_ok;
    logic [31:0]    sp_ext;

    always_comb
    begin
        a_st      = 32'(stk_rd_reg);
        a_sym     = ctl.act_goto ? 32'(left_reg) : 32'(sym_reg);
        a_oob     = (a_st >= 32'(STATES)) || (a_sym >= 32'(SYMBOLS));
        a_lin     = a_st * 32'(SYMBOLS) + a_sym;
        act_raddr = a_lin[AAW-1:0];
        ld_lin    = 32'(in_state) * 32'(SYMBOLS) + 32'(in_sym);
        ld_act_ok = (32'(in_state) < 32'(STATES)) && (32'(in_sym) < 32'(SYMBOLS));
        if (ctl.clr_en)
        begin
            act_we    = 1'b1;
            act_waddr = clr_cnt_reg;
            act_wdata = '0;
        end
        else
        begin
            act_we    = ctl.capture && (in_cmd == lrpe_pkg::CMD_LD_ACT) && ld_act_ok;
            act_waddr = ld_lin[AAW-1:0];
            act_wdata = {in_kind, in_val};
        end
    end

    always_ff @(posedge clk)
    begin
        act_rd_reg  <= act_mem[act_raddr];
        act_oob_reg <= a_oob;
        if (act_we)
        begin
            act_mem[act_waddr] <= act_wdata;
        end
    end

    assign act_kind = act_oob_reg ? lrpe_pkg::KIND_NONE : act_rd_reg[9:8];
    assign act_val  = act_rd_reg[7:0];

    assign rv     = 32'(act_val);
    assign rn_ext = 32'(in_rnum);

    always_ff @(posedge clk)
    begin
        rule_rd_reg <= rule_mem[rv[RAW-1:0]];
        if (ctl.capture && (in_cmd == lrpe_pkg::CMD_LD_RUL) && (rn_ext < 32'(RULES)))
        begin
            rule_mem[rn_ext[RAW-1:0]] <= {in_rlen, in_rleft};
        end
    end

    always_ff @(posedge clk)
    begin
        cmap_rd_reg <= cmap_mem[in_char];
        cmap_ok_reg <= cmap_vld_reg[in_char];
        if (ctl.capture && (in_cmd == lrpe_pkg::CMD_LD_MAP))
        begin
            cmap_mem[in_char] <= in_sym;
        end
    end

    assign r_len    = rule_rd_reg[9:6];
    assign sp_m1    = sp_reg - 1'b1;
    assign base_m1  = base_reg - 1'b1;
    assign shift_ok = !at_end_reg && (sp_reg < SPW'(STACK_DEPTH));
    assign red_ok   = (count_reg < CW'(RLIMIT)) && (rv < 32'(RULES));
    assign rule_ok  = (32'(r_len) <= 32'(MAX_RHS)) && (32'(sp_reg) > 32'(r_len));
    assign goto_ok  = (act_kind == lrpe_pkg::KIND_SHIFT) && (base_reg < SPW'(STACK_DEPTH));

    always_comb
    begin
        stk_raddr = ctl.stk_base ? base_m1[SAW-1:0] : sp_m1[SAW-1:0];
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SAW-1:0];
        stk_wdata = act_val;
        if (ctl.clr_en || (ctl.capture && (in_cmd == lrpe_pkg::CMD_START)))
        begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
        end
        else if (ctl.act_eval && (act_kind == lrpe_pkg::KIND_SHIFT) && shift_ok)
        begin
            stk_we = 1'b1;
        end
        else if (ctl.goto_eval && goto_ok)
        begin
            stk_we    = 1'b1;
            stk_waddr = base_reg[SAW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        stk_rd_reg <= stk_mem[stk_raddr];
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmap_vld_reg <= '0;
            sp_reg       <= SPW'(1);
            base_reg     <= '0;
            verdict_reg  <= lrpe_pkg::V_PARSING;
            end_sym_reg  <= '0;
            sym_reg      <= '0;
            left_reg     <= '0;
            at_end_reg   <= 1'b0;
            count_reg    <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                end_sym_reg <= cfg_wdata;
            end
            if (ctl.clr_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (ctl.capture)
            begin
                count_reg <= '0;
                case (in_cmd)
                    lrpe_pkg::CMD_START:
                    begin
                        sp_reg      <= SPW'(1);
                        verdict_reg <= lrpe_pkg::V_PARSING;
                    end
                    lrpe_pkg::CMD_LD_MAP:
                        cmap_vld_reg[in_char] <= 1'b1;
                    lrpe_pkg::CMD_CHAR:
                        at_end_reg <= 1'b0;
                    lrpe_pkg::CMD_END:
                    begin
                        at_end_reg <= 1'b1;
                        sym_reg    <= end_sym_reg;
                    end
                    default:
                        at_end_reg <= at_end_reg;
                endcase
            end
            if (ctl.map_chk)
            begin
                if (cmap_ok_reg)
                begin
                    sym_reg <= cmap_rd_reg;
                end
                else
                begin
                    verdict_reg <= lrpe_pkg::V_REJECT;
                end
            end
            if (ctl.act_eval)
            begin
                case (act_kind)
                    lrpe_pkg::KIND_ACCEPT:
                        verdict_reg <= lrpe_pkg::V_ACCEPT;
                    lrpe_pkg::KIND_SHIFT:
                    begin
                        if (shift_ok)
                        begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                        else
                        begin
                            verdict_reg <= lrpe_pkg::V_REJECT;
                        end
                    end
                    lrpe_pkg::KIND_REDUCE:
                    begin
                        if (!red_ok)
                        begin
                            verdict_reg <= lrpe_pkg::V_REJECT;
                        end
                    end
                    default:
                        verdict_reg <= lrpe_pkg::V_REJECT;
                endcase
            end
            if (ctl.rule_eval)
            begin
                if (rule_ok)
                begin
                    base_reg <= sp_reg - SPW'(r_len);
                    left_reg <= rule_rd_reg[5:0];
                end
                else
                begin
                    verdict_reg <= lrpe_pkg::V_REJECT;
                end
            end
            if (ctl.goto_eval)
            begin
                if (goto_ok)
                begin
                    sp_reg    <= base_reg + 1'b1;
                    count_reg <= count_reg + 1'b1;
                end
                else
                begin
                    verdict_reg <= lrpe_pkg::V_REJECT;
                end
            end
        end
    end

    assign sp_ext = 32'(sp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_data_reg <= {sp_ext[8:0], verdict_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'd0, out_data_reg};

    always_comb
    begin
        sts          = '0;
        sts.cmd      = in_user;
        sts.parsing  = (verdict_reg == lrpe_pkg::V_PARSING);
        sts.clr_last = (clr_cnt_reg == AAW'(ADEPTH - 1));
        sts.map_ok   = cmap_ok_reg;
        sts.act_more = (act_kind == lrpe_pkg::KIND_REDUCE) && red_ok;
        sts.rule_ok  = rule_ok;
        sts.goto_ok  = goto_ok;
        sts.out_free = !out_valid_reg || out_ready;
    end

endmodule
`default_nettype wire

>>> rtl/core/lr_table_driven_parse_engine.sv
// Loads, start and latched items go straight to result delivery; a character is
// first mapped to a symbol, and each reduction is set by the registered reads of
// stack, rule table and action table in series.
// One item at a time; the next item is taken once the result sits in the output register.
// Reset: a clearing pass over every action table entry runs before the first item is
// accepted; configuration writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module lr_table_driven_parse_engine #(
    parameter int STATES      = lrpe_pkg::STATES_DEF,
    parameter int SYMBOLS     = lrpe_pkg::SYMBOLS_DEF,
    parameter int RULES       = lrpe_pkg::RULES_DEF,
    parameter int STACK_DEPTH = lrpe_pkg::STACK_DEPTH_DEF,
    parameter int MAX_RHS     = lrpe_pkg::MAX_RHS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // state_index, symbol, char_code, action_kind, action_value,
    // rule_number, rule_length, rule_left
    input  wire logic [47:0] s_tdata,
    // cmd
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // verdict, stack_depth, zero fill
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_wen,
    input  wire logic [5:0]  cfg_wdata
);

    lrpe_pkg::ctl_t ctl;
    lrpe_pkg::sts_t sts;

    lrpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    lrpe_dp #(
        .STATES      (STATES),
        .SYMBOLS     (SYMBOLS),
        .RULES       (RULES),
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_RHS     (MAX_RHS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .in_user   (s_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule
`default_nettype wire
